>>> design/crsf_pkg.sv
// Shared types and constants for the CRSF receive-side frame parser.
// Used by the parser top level, its CRC unit and the port checker.
// No dependencies.
package crsf_pkg;

    // Frame geometry defaults
    localparam int FRAME_BYTES_DEF     = 64;
    localparam int EXT_PAYLOAD_MAX_DEF = 58;

    // Configuration port
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [7:0] OWN_ADDR_RST = 8'd200;

    // Fixed frame start addresses
    localparam logic [7:0] ADDR_BCAST = 8'h00;
    localparam logic [7:0] ADDR_EA    = 8'hEA;
    localparam logic [7:0] ADDR_EC    = 8'hEC;
    localparam logic [7:0] ADDR_EE    = 8'hEE;

    // Frame types
    localparam logic [7:0] TYPE_CHANNELS = 8'h16;
    localparam logic [7:0] TYPE_LINK     = 8'h14;
    localparam logic [7:0] TYPE_EXT_MIN  = 8'h28;

    // Channel frame: 22 payload bytes carry 16 packed 11-bit values
    localparam logic [7:0] CHAN_FRAME_SIZE = 8'd26;
    localparam logic [3:0] CHAN_LAST       = 4'd15;
    localparam logic [4:0] CHAN_BITS       = 5'd11;
    localparam logic [7:0] LINK_MIN_SIZE   = 8'd8;
    localparam logic [7:0] EXT_MIN_SIZE    = 8'd6;

    // Result kinds, carried on tuser
    localparam logic [1:0] KIND_CHAN = 2'd0;
    localparam logic [1:0] KIND_LINK = 2'd1;
    localparam logic [1:0] KIND_EXT  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam int TDATA_W = 72;

    // Control of the shared CRC unit
    typedef struct packed {
        logic clear;
        logic step;
    } crc_ctrl_t;

    // One result item
    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        channel_index;
        logic [10:0]       channel_value;
        logic [7:0]        link_quality;
        logic signed [7:0] snr;
        logic [7:0]        frame_type;
        logic [7:0]        destination;
        logic [7:0]        origin;
        logic [7:0]        payload_byte;
        logic [5:0]        payload_length;
        logic              last;
    } result_t;

endpackage

>>> design/crsf_crc_unit.sv
// CRC-8 DVB-S2 accumulator (polynomial 0xD5, init 0), one byte per step.
// Depends on crsf_pkg for the control struct.
module crsf_crc_unit
    import crsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  crc_ctrl_t ctrl,
    input  logic [7:0] data,
    output logic [7:0] crc
);

    localparam logic [7:0] POLY = 8'hD5;

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] x;
        x = c ^ d;
        for (int b = 0; b < 8; b++)
        begin
            x = x[7] ? ((x << 1) ^ POLY) : (x << 1);
        end
        return x;
    endfunction

    // next value: clear wins over step
    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.clear)
        begin
            crc_next = 8'h00;
        end
        else if (ctrl.step)
        begin
            crc_next = crc8_byte(crc_reg, data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 8'h00;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> design/crsf_frame_store.sv
// Frame buffer: one write port, one read port with registered read data.
// No package dependencies; depth handed down from the top level.
module crsf_frame_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data valid the cycle after rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/crsf_frame_parser.sv
// CRSF frame parser. Bytes are taken one per cycle while hunting/buffering.
// After the closing byte, a CRC pass reads the buffer one byte a cycle.
// Channel frame: 16 results from 22 buffer reads; extended frame: one result per payload byte read;
// link or CRC error: 1 result. Input is held off meanwhile.
// Async active-low reset: hunt for address, own_address = 200; buffer contents are not cleared.
module crsf_frame_parser
    import crsf_pkg::*;
#(
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int EXT_PAYLOAD_MAX = EXT_PAYLOAD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // received bytes
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [3:0] channel_index, [14:4] channel_value, [22:15] link_quality, [30:23] snr,
    // [38:31] frame_type, [46:39] destination, [54:47] origin, [62:55] payload_byte,
    // [68:63] payload_length, [71:69] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [7:0]    LEN_MAX  = 8'(FRAME_BYTES - 2);
    localparam logic [PW-1:0] POS_END  = PW'(FRAME_BYTES);
    localparam logic [PW-1:0] POS_TYPE = PW'(2);
    localparam logic [PW-1:0] POS_DEST = PW'(3);
    localparam logic [PW-1:0] POS_ORIG = PW'(4);
    localparam logic [PW-1:0] POS_LQ   = PW'(5);
    localparam logic [PW-1:0] POS_SNR  = PW'(6);
    localparam logic [7:0]    EXT_MAX  = 8'(EXT_PAYLOAD_MAX);

    // sequencer states
    localparam logic [2:0] ST_RX  = 3'd0;
    localparam logic [2:0] ST_CRC = 3'd1;
    localparam logic [2:0] ST_ONE = 3'd2;
    localparam logic [2:0] ST_CH  = 3'd3;
    localparam logic [2:0] ST_EXT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] size_reg, size_next;
    logic [PW-1:0] chk_reg, chk_next;
    logic          issued_reg, issued_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          byte_rdy_reg, byte_rdy_next;
    logic          one_err_reg, one_err_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    dest_reg, dest_next;
    logic [7:0]    orig_reg, orig_next;
    logic [7:0]    lq_reg, lq_next;
    logic [7:0]    snr_reg, snr_next;
    logic [17:0]   acc_reg, acc_next;
    logic [4:0]    have_reg, have_next;
    logic [3:0]    ch_idx_reg, ch_idx_next;
    logic [5:0]    ext_len_reg, ext_len_next;
    logic [5:0]    ext_cnt_reg, ext_cnt_next;
    logic          out_valid_reg, out_valid_next;
    result_t       res_reg, res_next;
    logic [7:0]    own_addr_reg, own_addr_next;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    crc_ctrl_t     crc_ctrl;
    logic [7:0]    crc_val;

    logic          out_free;
    logic [PW-1:0] size_m1;
    logic [7:0]    size8;
    logic [7:0]    ext_raw;
    logic          rx_is_addr;
    logic          ext_last;

    function automatic logic is_addr(input logic [7:0] v, input logic [7:0] own);
        return (v == own) || (v == ADDR_BCAST) || (v == ADDR_EA) ||
               (v == ADDR_EC) || (v == ADDR_EE);
    endfunction

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_OWN_ADDR) ? {24'h000000, own_addr_reg} : '0;

    always_comb
    begin
        own_addr_next = own_addr_reg;
        if (psel && penable && pwrite && (paddr == REG_OWN_ADDR))
        begin
            own_addr_next = pwdata[7:0];
        end
    end

    // buffer and CRC unit
    crsf_frame_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    crsf_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (mem_rdata),
        .crc   (crc_val)
    );

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign size_m1    = size_reg - PW'(1);
    assign size8      = 8'(size_reg);
    assign ext_raw    = size8 - EXT_MIN_SIZE;
    assign rx_is_addr = is_addr(s_axis_tdata, own_addr_reg);
    assign ext_last   = (ext_cnt_reg == (ext_len_reg - 6'd1));
    assign mem_raddr  = pos_reg[AW-1:0];
    assign s_axis_tready = (state_reg == ST_RX);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        size_next     = size_reg;
        chk_next      = chk_reg;
        issued_next   = issued_reg;
        rd_pend_next  = 1'b0;
        byte_rdy_next = byte_rdy_reg;
        one_err_next  = one_err_reg;
        type_next     = type_reg;
        dest_next     = dest_reg;
        orig_next     = orig_reg;
        lq_next       = lq_reg;
        snr_next      = snr_reg;
        acc_next      = acc_reg;
        have_next     = have_reg;
        ch_idx_next   = ch_idx_reg;
        ext_len_next  = ext_len_reg;
        ext_cnt_next  = ext_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        crc_ctrl      = '0;

        unique case (state_reg)
            ST_RX:
            begin
                if (s_axis_tvalid)
                begin
                    if (pos_reg == '0)
                    begin
                        // hunting for a frame start
                        if (rx_is_addr)
                        begin
                            pos_next  = PW'(1);
                            size_next = '0;
                        end
                    end
                    else if (pos_reg == PW'(1))
                    begin
                        // length byte
                        if ((s_axis_tdata < 8'd2) || (s_axis_tdata > LEN_MAX))
                        begin
                            pos_next  = rx_is_addr ? PW'(1) : '0;
                            size_next = '0;
                        end
                        else
                        begin
                            pos_next  = PW'(2);
                            size_next = PW'(s_axis_tdata) + PW'(2);
                        end
                    end
                    else if (pos_reg >= POS_END)
                    begin
                        pos_next  = '0;
                        size_next = '0;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        pos_next = pos_reg + PW'(1);
                        if ((size_reg != '0) && ((pos_reg + PW'(1)) >= size_reg))
                        begin
                            // frame complete: start the CRC pass
                            state_next    = ST_CRC;
                            pos_next      = POS_TYPE;
                            issued_next   = 1'b0;
                            crc_ctrl.clear = 1'b1;
                        end
                    end
                end
            end

            ST_CRC:
            begin
                // issue reads of positions 2 .. size-1
                if (!issued_reg)
                begin
                    mem_re       = 1'b1;
                    chk_next     = pos_reg;
                    pos_next     = pos_reg + PW'(1);
                    rd_pend_next = 1'b1;
                    if (pos_reg == size_m1)
                    begin
                        issued_next = 1'b1;
                    end
                end
                // consume read data in the cycle after the read
                if (rd_pend_reg)
                begin
                    if (chk_reg == size_m1)
                    begin
                        rd_pend_next = 1'b0;
                        if (crc_val != mem_rdata)
                        begin
                            state_next   = ST_ONE;
                            one_err_next = 1'b1;
                        end
                        else if (type_reg == TYPE_CHANNELS)
                        begin
                            if (size8 == CHAN_FRAME_SIZE)
                            begin
                                state_next  = ST_CH;
                                pos_next    = POS_DEST;
                                acc_next    = '0;
                                have_next   = '0;
                                ch_idx_next = '0;
                            end
                            else
                            begin
                                state_next = ST_RX;
                                pos_next   = '0;
                                size_next  = '0;
                            end
                        end
                        else if ((type_reg == TYPE_LINK) && (size8 >= LINK_MIN_SIZE))
                        begin
                            state_next   = ST_ONE;
                            one_err_next = 1'b0;
                        end
                        else if ((type_reg >= TYPE_EXT_MIN) && (size8 >= EXT_MIN_SIZE))
                        begin
                            state_next    = ST_EXT;
                            pos_next      = POS_LQ;
                            ext_cnt_next  = '0;
                            byte_rdy_next = 1'b0;
                            ext_len_next  = (ext_raw > EXT_MAX) ? EXT_MAX[5:0] : ext_raw[5:0];
                        end
                        else
                        begin
                            state_next = ST_RX;
                            pos_next   = '0;
                            size_next  = '0;
                        end
                    end
                    else
                    begin
                        crc_ctrl.step = 1'b1;
                        if (chk_reg == POS_TYPE) type_next = mem_rdata;
                        if (chk_reg == POS_DEST) dest_next = mem_rdata;
                        if (chk_reg == POS_ORIG) orig_next = mem_rdata;
                        if (chk_reg == POS_LQ)   lq_next   = mem_rdata;
                        if (chk_reg == POS_SNR)  snr_next  = mem_rdata;
                    end
                end
            end

            ST_ONE:
            begin
                // CRC error or link statistics: single result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    if (one_err_reg)
                    begin
                        res_next.kind = KIND_ERR;
                    end
                    else
                    begin
                        res_next.kind         = KIND_LINK;
                        res_next.link_quality = lq_reg;
                        res_next.snr          = snr_reg;
                    end
                    state_next = ST_RX;
                    pos_next   = '0;
                    size_next  = '0;
                end
            end

            ST_CH:
            begin
                // unpack 11-bit channels, LSB first, one byte read at a time
                if (rd_pend_reg)
                begin
                    acc_next  = acc_reg | (18'(mem_rdata) << have_reg);
                    have_next = have_reg + 5'd8;
                end
                else if (have_reg < CHAN_BITS)
                begin
                    mem_re       = 1'b1;
                    pos_next     = pos_reg + PW'(1);
                    rd_pend_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    res_next               = '0;
                    res_next.kind          = KIND_CHAN;
                    res_next.channel_index = ch_idx_reg;
                    res_next.channel_value = acc_reg[10:0];
                    res_next.last          = (ch_idx_reg == CHAN_LAST);
                    acc_next    = acc_reg >> CHAN_BITS;
                    have_next   = have_reg - CHAN_BITS;
                    ch_idx_next = ch_idx_reg + 4'd1;
                    if (ch_idx_reg == CHAN_LAST)
                    begin
                        state_next = ST_RX;
                        pos_next   = '0;
                        size_next  = '0;
                    end
                end
            end

            ST_EXT:
            begin
                // one result per extended payload byte, or one empty result
                if (ext_len_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next      = 1'b1;
                        res_next            = '0;
                        res_next.kind       = KIND_EXT;
                        res_next.frame_type = type_reg;
                        res_next.destination = dest_reg;
                        res_next.origin     = orig_reg;
                        res_next.last       = 1'b1;
                        state_next = ST_RX;
                        pos_next   = '0;
                        size_next  = '0;
                    end
                end
                else if (rd_pend_reg)
                begin
                    byte_rdy_next = 1'b1;
                end
                else if (byte_rdy_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next          = 1'b1;
                        res_next                = '0;
                        res_next.kind           = KIND_EXT;
                        res_next.frame_type     = type_reg;
                        res_next.destination    = dest_reg;
                        res_next.origin         = orig_reg;
                        res_next.payload_byte   = mem_rdata;
                        res_next.payload_length = ext_len_reg;
                        res_next.last           = ext_last;
                        byte_rdy_next = 1'b0;
                        ext_cnt_next  = ext_cnt_reg + 6'd1;
                        if (ext_last)
                        begin
                            state_next = ST_RX;
                            pos_next   = '0;
                            size_next  = '0;
                        end
                    end
                end
                else
                begin
                    mem_re       = 1'b1;
                    pos_next     = pos_reg + PW'(1);
                    rd_pend_next = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_RX;
                pos_next   = '0;
                size_next  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            pos_reg       <= '0;
            size_reg      <= '0;
            issued_reg    <= 1'b0;
            rd_pend_reg   <= 1'b0;
            byte_rdy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            own_addr_reg  <= OWN_ADDR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            size_reg      <= size_next;
            issued_reg    <= issued_next;
            rd_pend_reg   <= rd_pend_next;
            byte_rdy_reg  <= byte_rdy_next;
            out_valid_reg <= out_valid_next;
            own_addr_reg  <= own_addr_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        chk_reg     <= chk_next;
        one_err_reg <= one_err_next;
        type_reg    <= type_next;
        dest_reg    <= dest_next;
        orig_reg    <= orig_next;
        lq_reg      <= lq_next;
        snr_reg     <= snr_next;
        acc_reg     <= acc_next;
        have_reg    <= have_next;
        ch_idx_reg  <= ch_idx_next;
        ext_len_reg <= ext_len_next;
        ext_cnt_reg <= ext_cnt_next;
        res_reg     <= res_next;
    end

    // result channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {3'b000, res_reg.payload_length, res_reg.payload_byte,
                            res_reg.origin, res_reg.destination, res_reg.frame_type,
                            res_reg.snr, res_reg.link_quality, res_reg.channel_value,
                            res_reg.channel_index};

endmodule

>>> design/crsf_checker.sv
// Port-level checks for the CRSF frame parser, attached by bind.
// Depends on crsf_pkg for result kinds and the tdata width.
module crsf_checker
    import crsf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast))
    else $error("stalled result changed");

    // error and link results stand alone
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == KIND_ERR) || (m_axis_tuser == KIND_LINK))
        |-> m_axis_tlast)
    else $error("single result without tlast");

    // input is held off while a frame still has results to give
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a frame's results");

    // the last channel result is channel 15 and no other
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_CHAN) |->
        ((m_axis_tdata[3:0] == CHAN_LAST) == m_axis_tlast))
    else $error("channel tlast out of place");

    // extended-frame fields are zero on other kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_EXT) |-> (m_axis_tdata[68:31] == '0))
    else $error("extended fields set on a non-extended result");

endmodule

bind crsf_frame_parser crsf_checker u_crsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for crsf_frame_parser: feeds CRSF byte traffic with
// bursts, gaps and output stalls, predicts each result and checks every transfer.
// Depends on crsf_pkg and the crsf_frame_parser RTL.
module tb_top;
    import crsf_pkg::*;

    localparam int          FRAME_LEN_MAX   = FRAME_BYTES_DEF;
    localparam int          EXT_LEN_MAX     = EXT_PAYLOAD_MAX_DEF;
    localparam logic [7:0]  CRC_POLY        = 8'hD5;
    localparam int          CHAN_PAYLOAD    = 22;
    localparam int          RAND_PHASE_BYTES = 36;
    localparam int          SETTLE_CYCLES   = 200;
    localparam int          MAX_REPORTS     = 10;

    // DUT ports, all inputs start at known values
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'd0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    // Byte source state
    logic [7:0]           rx_pending[$];
    logic [7:0]           payload_buf[$];
    int unsigned          rx_queued = 0;
    int unsigned          rx_accepted = 0;
    int unsigned          burst_left = 0;
    int unsigned          gap_left = 0;

    // Sink stall state
    logic [15:0]          ready_tick = '0;
    logic [1:0]           stall_mode = 2'd0;

    // Parser prediction state
    logic [7:0]           own_addr_m = OWN_ADDR_RST;
    logic [7:0]           frame_buf[FRAME_LEN_MAX];
    int unsigned          buf_pos = 0;
    int unsigned          buf_size = 0;
    result_t              results_due[$];
    int unsigned          mismatches = 0;

    always #4 clk = ~clk;

    crsf_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // CRC-8 DVB-S2, one byte
    function automatic logic [7:0] crc8_d5_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        int         b;
        c = crc ^ data;
        for (b = 0; b < 8; b++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic bit is_frame_start(input logic [7:0] v);
        return v == own_addr_m || v == ADDR_BCAST || v == ADDR_EA || v == ADDR_EC ||
               v == ADDR_EE;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf({"kind=%0d idx=%0d val=%0d lq=%0d snr=%0d type=%02h dst=%02h ",
                          "org=%02h pbyte=%02h plen=%0d last=%0d"},
                         r.kind, r.channel_index, r.channel_value, r.link_quality, r.snr,
                         r.frame_type, r.destination, r.origin, r.payload_byte,
                         r.payload_length, r.last);
    endfunction

    // Work out the results of a completed frame held in frame_buf
    task automatic decode_frame();
        result_t     r;
        logic [7:0]  crc;
        logic [7:0]  ftype;
        logic [31:0] acc;
        int unsigned plen, ext, n, have, p, i;
        crc = 8'd0;
        for (i = 2; i < buf_size - 1; i++)
            crc = crc8_d5_step(crc, frame_buf[i]);
        if (crc != frame_buf[buf_size - 1]) begin
            r = '0;
            r.kind = KIND_ERR;
            r.last = 1'b1;
            results_due.push_back(r);
            return;
        end
        ftype = frame_buf[2];
        plen = buf_size - 4;
        if (ftype == TYPE_CHANNELS) begin
            if (plen != CHAN_PAYLOAD)
                return;
            // 16 little-endian packed 11-bit values
            acc = '0;
            have = 0;
            p = 3;
            for (i = 0; i <= CHAN_LAST; i++) begin
                while (have < CHAN_BITS) begin
                    acc = acc | ({24'd0, frame_buf[p]} << have);
                    p++;
                    have += 8;
                end
                r = '0;
                r.kind = KIND_CHAN;
                r.channel_index = i[3:0];
                r.channel_value = acc[10:0];
                r.last = (i == CHAN_LAST);
                results_due.push_back(r);
                acc = acc >> CHAN_BITS;
                have -= CHAN_BITS;
            end
        end else if (ftype == TYPE_LINK && plen >= 4) begin
            r = '0;
            r.kind = KIND_LINK;
            r.link_quality = frame_buf[5];
            r.snr = frame_buf[6];
            r.last = 1'b1;
            results_due.push_back(r);
        end else if (ftype >= TYPE_EXT_MIN && plen >= 2) begin
            ext = (plen - 2 > EXT_LEN_MAX) ? EXT_LEN_MAX : plen - 2;
            n = (ext != 0) ? ext : 1;
            for (i = 0; i < n; i++) begin
                r = '0;
                r.kind = KIND_EXT;
                r.frame_type = ftype;
                r.destination = frame_buf[3];
                r.origin = frame_buf[4];
                r.payload_byte = (ext != 0) ? frame_buf[5 + i] : 8'd0;
                r.payload_length = ext[5:0];
                r.last = (i == n - 1);
                results_due.push_back(r);
            end
        end
    endtask

    // Advance the frame tracker by one received byte
    task automatic predict_byte(input logic [7:0] v);
        if (buf_pos == 0) begin
            if (is_frame_start(v)) begin
                frame_buf[0] = v;
                buf_pos = 1;
                buf_size = 0;
            end
        end else if (buf_pos == 1) begin
            if (v < 2 || v > FRAME_LEN_MAX - 2) begin
                // bad length: an address byte restarts the frame
                if (is_frame_start(v)) begin
                    frame_buf[0] = v;
                    buf_pos = 1;
                end else begin
                    buf_pos = 0;
                end
                buf_size = 0;
            end else begin
                frame_buf[1] = v;
                buf_pos = 2;
                buf_size = v + 2;
            end
        end else if (buf_pos >= FRAME_LEN_MAX) begin
            buf_pos = 0;
            buf_size = 0;
        end else begin
            frame_buf[buf_pos] = v;
            buf_pos++;
            if (buf_size > 0 && buf_pos >= buf_size) begin
                decode_frame();
                buf_pos = 0;
                buf_size = 0;
            end
        end
    endtask

    // Byte source: bursts of random length with random gaps
    always @(posedge clk) begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready)) begin
            if (gap_left > 0 || rx_pending.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= rx_pending.pop_front();
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Result sink: a new random stall pattern each time ready_tick[5:0] reaches 63
    always @(posedge clk) begin
        ready_tick <= ready_tick + 16'd1;
        if (ready_tick[5:0] == 6'd63)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= (ready_tick[2:0] < 3'd5);
            default: m_axis_tready <= ready_tick[3];
        endcase
    end

    // Track accepted bytes and check each result transfer
    always @(posedge clk) begin : check_results
        result_t seen;
        result_t want;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata);
                rx_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind           = m_axis_tuser;
                seen.channel_index  = m_axis_tdata[3:0];
                seen.channel_value  = m_axis_tdata[14:4];
                seen.link_quality   = m_axis_tdata[22:15];
                seen.snr            = m_axis_tdata[30:23];
                seen.frame_type     = m_axis_tdata[38:31];
                seen.destination    = m_axis_tdata[46:39];
                seen.origin         = m_axis_tdata[54:47];
                seen.payload_byte   = m_axis_tdata[62:55];
                seen.payload_length = m_axis_tdata[68:63];
                seen.last           = m_axis_tlast;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR %0t: unexpected result %s", $realtime, fmt_result(seen));
                end else begin
                    want = results_due.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR %0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt_result(want), fmt_result(seen));
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        rx_queued++;
    endtask

    task automatic fill_payload(input int unsigned n);
        payload_buf.delete();
        repeat (n) payload_buf.push_back(8'($urandom));
    endtask

    // Address, length, type, payload_buf, crc (optionally damaged)
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] ftype, input bit corrupt);
        logic [7:0] crc;
        int         i;
        crc = crc8_d5_step(8'd0, ftype);
        send_byte(addr);
        send_byte(8'(payload_buf.size() + 2));
        send_byte(ftype);
        for (i = 0; i < payload_buf.size(); i++) begin
            send_byte(payload_buf[i]);
            crc = crc8_d5_step(crc, payload_buf[i]);
        end
        send_byte(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
    endtask

    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 5))
            0:       return ADDR_BCAST;
            1:       return ADDR_EA;
            2:       return ADDR_EC;
            3:       return ADDR_EE;
            default: return own_addr_m;
        endcase
    endfunction

    // Mostly well-formed frames, some noise and broken frames
    task automatic random_traffic(input int unsigned nbytes);
        int unsigned sel, target;
        logic [7:0]  ftype;
        target = rx_queued + nbytes;
        while (rx_queued < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                if (sel < 18) begin
                    ftype = TYPE_CHANNELS;
                    fill_payload(CHAN_PAYLOAD);
                end else if (sel < 32) begin
                    ftype = TYPE_LINK;
                    fill_payload($urandom_range(4, 8));
                end else if (sel < 62) begin
                    ftype = 8'($urandom_range(TYPE_EXT_MIN, 255));
                    fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                             : $urandom_range(2, 12));
                end else begin
                    // any type, mostly no output or short payloads
                    ftype = 8'($urandom);
                    fill_payload($urandom_range(0, 24));
                end
                send_frame(pick_address(), ftype, $urandom_range(0, 9) == 0);
            end else if (sel < 87) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
                send_byte(pick_address());
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                          : 8'($urandom_range(63, 255)));
                end else begin
                    // truncated frame, swallows what follows
                    send_byte(8'($urandom_range(2, 30)));
                    repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
                end
            end
        end
    endtask

    // Wait for all bytes taken, all results seen, then let the parser settle
    task automatic wait_idle();
        while (rx_accepted != rx_queued || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_OWN_ADDR;
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        own_addr_m = value;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // noise while hunting, then bad length bytes
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(ADDR_EA);
        send_byte(ADDR_BCAST);      // length 0 is an address: new start
        send_byte(ADDR_EA);         // length 0xEA too
        send_byte(8'd63);           // too long, not an address: hunt
        send_byte(OWN_ADDR_RST);
        send_byte(8'd1);            // too short: hunt

        // channel frame: all-ones then all-zero values
        payload_buf.delete();
        repeat (11) payload_buf.push_back(8'hFF);
        repeat (11) payload_buf.push_back(8'h00);
        send_frame(OWN_ADDR_RST, TYPE_CHANNELS, 1'b0);

        // link frames with extreme quality and snr
        payload_buf = '{8'h00, 8'h00, 8'hFF, 8'h80};
        send_frame(ADDR_EE, TYPE_LINK, 1'b0);
        payload_buf = '{8'h11, 8'h22, 8'h00, 8'h7F, 8'h33};
        send_frame(ADDR_EC, TYPE_LINK, 1'b0);

        // extended frame with empty payload, then with one byte
        payload_buf = '{8'hEA, 8'hC8};
        send_frame(ADDR_EC, 8'hFF, 1'b0);
        payload_buf = '{8'h00, 8'hFF, 8'hA5};
        send_frame(ADDR_BCAST, TYPE_EXT_MIN, 1'b0);

        // crc error on the shortest frame
        payload_buf.delete();
        send_frame(ADDR_BCAST, TYPE_LINK, 1'b1);

        // good crc but nothing to report
        fill_payload(3);
        send_frame(ADDR_EA, 8'h10, 1'b0);
        send_frame(ADDR_EA, TYPE_LINK, 1'b0);
        fill_payload(CHAN_PAYLOAD - 1);
        send_frame(ADDR_EE, TYPE_CHANNELS, 1'b0);
        fill_payload(1);
        send_frame(ADDR_EC, 8'h30, 1'b0);
        fill_payload(4);
        send_frame(ADDR_EA, 8'h27, 1'b0);

        // longest frame: extended payload exactly at the limit
        fill_payload(FRAME_LEN_MAX - 4);
        send_frame(OWN_ADDR_RST, TYPE_EXT_MIN, 1'b0);
        wait_idle();

        write_own_address(8'h00);
        random_traffic(RAND_PHASE_BYTES);
        wait_idle();

        write_own_address(8'hFF);
        random_traffic(RAND_PHASE_BYTES);
        wait_idle();

        write_own_address(8'($urandom_range(1, 254)));
        random_traffic(RAND_PHASE_BYTES);
        wait_idle();

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> files.f
design/crsf_pkg.sv
design/crsf_crc_unit.sv
design/crsf_frame_store.sv
design/crsf_frame_parser.sv
design/crsf_checker.sv
tb/sv/tb_top.sv
